// ----- hw/rtl/lkvc_pkg.sv -----
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types and constants for the LRU key-value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

   localparam int KEY_SPACE_DEFAULT = 128;
   localparam int SLOTS_DEFAULT     = 16;

   localparam int CMD_W   = 1;
   localparam int KEY_W   = 8;
   localparam int VALUE_W = 32;
   localparam int EVK_W   = 7;
   localparam int CAP_W   = 5;

   localparam logic [CMD_W-1:0] CMD_GET = 1'b0;
   localparam logic [CMD_W-1:0] CMD_PUT = 1'b1;

   localparam logic [CAP_W-1:0]   CAPACITY_RESET = 5'd16;
   localparam logic [VALUE_W-1:0] MISS_VALUE     = 32'hFFFF_FFFF;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_CAPACITY = 1'b0;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_PROMOTE,
      OP_INSERT
   } op_type;

   typedef struct packed {
      op_type op;
      logic   evict;
   } cell_ctl_type;

endpackage

// ----- hw/rtl/lkvc_cell.sv -----
// ----------------------------------------------------------------------------
// lkvc_cell
// One recency slot: holds a key, a value and a valid bit, compares against
// the request key and takes its lower neighbor's contents on a shift.
// ----------------------------------------------------------------------------
module lkvc_cell #(
   parameter int KEY_W = lkvc_pkg::EVK_W
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lkvc_pkg::cell_ctl_type        ctl,
   input  logic [KEY_W-1:0]              req_key,
   input  logic [KEY_W-1:0]              prev_key,
   input  logic [lkvc_pkg::VALUE_W-1:0]  prev_value,
   input  logic                          prev_valid,
   input  logic                          seen_in,
   input  logic [lkvc_pkg::VALUE_W-1:0]  hit_value_in,
   input  logic [KEY_W-1:0]              evict_key_in,
   output logic [KEY_W-1:0]              key_out,
   output logic [lkvc_pkg::VALUE_W-1:0]  value_out,
   output logic                          valid_out,
   output logic                          match,
   output logic                          seen_out,
   output logic [lkvc_pkg::VALUE_W-1:0]  hit_value_out,
   output logic [KEY_W-1:0]              evict_key_out
);

   logic [KEY_W-1:0]             key_ff, key_in;
   logic [lkvc_pkg::VALUE_W-1:0] value_ff, value_in;
   logic                         valid_ff, valid_in;
   logic                         prev_last;

   assign match         = valid_ff && (key_ff == req_key);
   assign seen_out      = seen_in | match;
   assign hit_value_out = hit_value_in | (match ? value_ff : '0);
   assign prev_last     = prev_valid & ~valid_ff;
   assign evict_key_out = evict_key_in | (prev_last ? prev_key : '0);

   assign key_out   = key_ff;
   assign value_out = value_ff;
   assign valid_out = valid_ff;

   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      valid_in = valid_ff;
      case (ctl.op)
         lkvc_pkg::OP_PROMOTE: begin
            if (!seen_in) begin
               key_in   = prev_key;
               value_in = prev_value;
            end
         end
         lkvc_pkg::OP_INSERT: begin
            key_in   = prev_key;
            value_in = prev_value;
            valid_in = prev_valid & ~(ctl.evict & prev_last);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

// ----- hw/rtl/lru_key_value_cache_top.sv -----
// ----------------------------------------------------------------------------
// lru_key_value_cache_top
// Fully associative key-value cache with least-recently-used replacement.
//
// A request beat on req_ carries a command (get or put), a key and a value.
// Each request yields exactly one response beat on rsp_: found, the read
// value on a get hit (all ones otherwise), rejected for keys outside the key
// space, and the evicted flag and key when a put pushes out the oldest pair.
// The request is registered first; then every slot compares its key in
// parallel, hit and eviction data ripple along the slot chain, and the whole
// recency list shifts by one on the same edge as the response register loads.
// The next request is taken the cycle after the response register loads,
// set by the single request register in front of the slot chain.
// A stalled rsp_ready holds the response; one further request is accepted
// and waits in the request register until the response is taken.
// Reset empties every slot and sets capacity to 16; no clearing pass.
// The CSR port holds capacity at address 0; write it only while idle.
// ----------------------------------------------------------------------------
module lru_key_value_cache_top #(
   parameter int KEY_SPACE = lkvc_pkg::KEY_SPACE_DEFAULT,
   parameter int SLOTS     = lkvc_pkg::SLOTS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [lkvc_pkg::CMD_W-1:0]           req_command,
   input  logic [lkvc_pkg::KEY_W-1:0]           req_lookup_key,
   input  logic signed [lkvc_pkg::VALUE_W-1:0]  req_write_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_found,
   output logic signed [lkvc_pkg::VALUE_W-1:0]  rsp_read_value,
   output logic                                 rsp_rejected,
   output logic                                 rsp_evicted,
   output logic [lkvc_pkg::EVK_W-1:0]           rsp_evicted_key,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [lkvc_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [lkvc_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [lkvc_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);

   localparam int SKEY_W = $clog2(KEY_SPACE);
   localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   logic                              busy_ff, busy_in;
   logic [lkvc_pkg::CMD_W-1:0]        cmd_ff;
   logic [lkvc_pkg::KEY_W-1:0]        key_ff;
   logic [lkvc_pkg::VALUE_W-1:0]      wval_ff;
   logic [lkvc_pkg::CAP_W-1:0]        cap_ff;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_found_ff;
   logic signed [lkvc_pkg::VALUE_W-1:0] rsp_read_value_ff;
   logic                              rsp_rejected_ff;
   logic                              rsp_evicted_ff;
   logic [lkvc_pkg::EVK_W-1:0]        rsp_evicted_key_ff;

   logic                              req_fire;
   logic                              exec;
   logic                              rejected_now;
   logic                              hit;
   logic                              evict;
   logic                              evicted_now;
   logic [IDX_W-1:0]                  cap_idx;
   logic [SKEY_W-1:0]                 key_short;
   logic [SKEY_W-1:0]                 evict_key_final;
   lkvc_pkg::cell_ctl_type            ctl;
   logic                              csr_write;

   logic [SKEY_W-1:0]                 link_key   [SLOTS+1];
   logic [lkvc_pkg::VALUE_W-1:0]      link_value [SLOTS+1];
   logic                              link_valid [SLOTS+1];
   logic                              seen       [SLOTS+1];
   logic [lkvc_pkg::VALUE_W-1:0]      hit_value  [SLOTS+1];
   logic [SKEY_W-1:0]                 evict_key  [SLOTS+1];
   logic [SLOTS-1:0]                  valid_vec;
   logic [SLOTS-1:0]                  match_vec;

   assign req_ready = ~busy_ff;
   assign req_fire  = req_valid & req_ready;
   assign exec      = busy_ff & (~rsp_valid_ff | rsp_ready);
   assign busy_in   = req_fire | (busy_ff & ~exec);

   assign key_short    = key_ff[SKEY_W-1:0];
   assign rejected_now = ({1'b0, key_ff} >= 9'(KEY_SPACE));
   assign hit          = seen[SLOTS];
   assign evict        = valid_vec[cap_idx];

   always_comb begin
      if (cap_ff == '0) begin
         cap_idx = '0;
      end else if (int'(cap_ff) > SLOTS) begin
         cap_idx = IDX_W'(SLOTS - 1);
      end else begin
         cap_idx = IDX_W'(cap_ff - 5'd1);
      end
   end

   always_comb begin
      ctl.op    = lkvc_pkg::OP_HOLD;
      ctl.evict = evict;
      if (exec && !rejected_now) begin
         if (hit) begin
            ctl.op = lkvc_pkg::OP_PROMOTE;
         end else if (cmd_ff == lkvc_pkg::CMD_PUT) begin
            ctl.op = lkvc_pkg::OP_INSERT;
         end
      end
   end

   assign link_key[0]   = key_short;
   assign link_value[0] = (cmd_ff == lkvc_pkg::CMD_PUT) ? wval_ff : hit_value[SLOTS];
   assign link_valid[0] = 1'b1;
   assign seen[0]       = 1'b0;
   assign hit_value[0]  = '0;
   assign evict_key[0]  = '0;

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      lkvc_cell #(
         .KEY_W(SKEY_W)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctl          (ctl),
         .req_key      (key_short),
         .prev_key     (link_key[i]),
         .prev_value   (link_value[i]),
         .prev_valid   (link_valid[i]),
         .seen_in      (seen[i]),
         .hit_value_in (hit_value[i]),
         .evict_key_in (evict_key[i]),
         .key_out      (link_key[i+1]),
         .value_out    (link_value[i+1]),
         .valid_out    (link_valid[i+1]),
         .match        (match_vec[i]),
         .seen_out     (seen[i+1]),
         .hit_value_out(hit_value[i+1]),
         .evict_key_out(evict_key[i+1])
      );
      assign valid_vec[i] = link_valid[i+1];
   end

   assign evict_key_final = evict_key[SLOTS] | (link_valid[SLOTS] ? link_key[SLOTS] : '0);
   assign evicted_now     = (ctl.op == lkvc_pkg::OP_INSERT) & evict;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (exec) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cap_ff       <= lkvc_pkg::CAPACITY_RESET;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write && csr_paddr[2] == lkvc_pkg::CSR_CAPACITY) begin
            cap_ff <= csr_pwdata[lkvc_pkg::CAP_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff  <= req_command;
         key_ff  <= req_lookup_key;
         wval_ff <= req_write_value;
      end
      if (exec) begin
         rsp_found_ff       <= ~rejected_now & hit;
         rsp_read_value_ff  <= (~rejected_now && hit && cmd_ff == lkvc_pkg::CMD_GET) ?
                               hit_value[SLOTS] : lkvc_pkg::MISS_VALUE;
         rsp_rejected_ff    <= rejected_now;
         rsp_evicted_ff     <= evicted_now;
         rsp_evicted_key_ff <= evicted_now ? lkvc_pkg::EVK_W'(evict_key_final) : '0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_rejected    = rsp_rejected_ff;
   assign rsp_evicted     = rsp_evicted_ff;
   assign rsp_evicted_key = rsp_evicted_key_ff;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == lkvc_pkg::CSR_CAPACITY) begin
         csr_prdata = lkvc_pkg::CSR_DATA_W'(cap_ff);
      end
   end

   a_valid_thermometer : assert property (@(posedge clock) disable iff (reset)
      $onehot({1'b0, valid_vec} + (SLOTS+1)'(1)))
      else $error("slot valid bits are not contiguous from the front");

   a_single_match : assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_vec))
      else $error("key held in more than one slot");

   a_exec_responds : assert property (@(posedge clock) disable iff (reset)
      exec |=> rsp_valid_ff)
      else $error("executed request produced no response beat");

   a_insert_fills_front : assert property (@(posedge clock) disable iff (reset)
      (exec && ctl.op == lkvc_pkg::OP_INSERT) |=> valid_vec[0])
      else $error("insert left the front slot empty");

endmodule
